// ===== sv/strict_priority_multi_queue_macros.svh =====
// assertion macros for the strict priority multi queue
`ifndef STRICT_PRIORITY_MULTI_QUEUE_MACROS_SVH
`define STRICT_PRIORITY_MULTI_QUEUE_MACROS_SVH

// same cycle implication
`define SPMQ_CHECK_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next cycle implication
`define SPMQ_CHECK_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/spmq_pkg.sv =====
// package with types and constants of the strict priority multi queue
`default_nettype none
package spmq_pkg;

	localparam int N_QUEUES_DEF   = 8;
	localparam int DEPTH_DEF      = 128;
	localparam int TAG_WIDTH_DEF  = 8;

	localparam int CFG_W  = 4;
	localparam int QIDX_W = 3;
	localparam int TAG_W  = 8;

	typedef enum logic {
		OP_ENQ = 1'b0,
		OP_DEQ = 1'b1
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_FULL    = 2'd1,
		ST_INVALID = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef struct packed {
		opcode_t             opcode;
		logic [QIDX_W-1:0]   queue_index;
		logic [TAG_W-1:0]    item_tag;
	} cmd_word_t;

	typedef struct packed {
		status_t             status;
		logic [TAG_W-1:0]    out_tag;
		logic [QIDX_W-1:0]   served_queue;
	} result_word_t;

	typedef struct packed {
		logic                deq_ok;
		status_t             status;
		logic [QIDX_W-1:0]   served_queue;
	} step_info_t;

endpackage
`default_nettype wire

// ===== sv/spmq_ram.sv =====
// generic simple dual port ram with registered read
`default_nettype none
module spmq_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

// ===== sv/spmq_ptrs.sv =====
// head and tail pointers, queue count and priority selection
`default_nettype none
`include "strict_priority_multi_queue_macros.svh"
module spmq_ptrs import spmq_pkg::*; #(
	parameter int N_QUEUES   = N_QUEUES_DEF,
	parameter int DEPTH      = DEPTH_DEF,
	parameter int TAG_WIDTH  = TAG_WIDTH_DEF,
	localparam int AW = $clog2(N_QUEUES * DEPTH)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	input  wire logic                 go,
	input  wire cmd_word_t            cmd,
	output logic                      mem_we,
	output logic      [AW-1:0]        mem_waddr,
	output logic      [TAG_WIDTH-1:0] mem_wdata,
	output logic      [AW-1:0]        mem_raddr,
	output step_info_t                info
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int QIW   = (N_QUEUES > 1) ? $clog2(N_QUEUES) : 1;
	localparam int CNT_W = $clog2(N_QUEUES + 1);

	logic [PTR_W-1:0]      head_q [N_QUEUES];
	logic [PTR_W-1:0]      tail_q [N_QUEUES];
	logic [CNT_W-1:0]      qiu_q;

	logic [N_QUEUES-1:0]   nonempty;
	logic [N_QUEUES-1:0]   elig;
	logic                  found;
	logic [QIW-1:0]        fidx;
	logic [QIW-1:0]        qsel;
	logic                  idx_ok;
	logic                  full;
	logic                  is_enq;
	logic [PTR_W-1:0]      tail_nxt;
	logic [PTR_W-1:0]      head_nxt;
	logic                  enq_go;
	logic                  deq_go;

	function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
		ring_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_comb begin
		for (int i = 0; i < N_QUEUES; i++) begin
			nonempty[i] = head_q[i] != tail_q[i];
			elig[i]     = nonempty[i] && (32'(i) < 32'(qiu_q));
		end
	end

	// lowest numbered eligible queue wins
	always_comb begin
		found = 1'b0;
		fidx  = '0;
		for (int i = N_QUEUES - 1; i >= 0; i--) begin
			if (elig[i]) begin
				found = 1'b1;
				fidx  = QIW'(i);
			end
		end
	end

	assign is_enq   = cmd.opcode == OP_ENQ;
	assign qsel     = QIW'(cmd.queue_index);
	assign idx_ok   = 32'(cmd.queue_index) < 32'(qiu_q);
	assign tail_nxt = ring_next(tail_q[qsel]);
	assign full     = tail_nxt == head_q[qsel];
	assign head_nxt = ring_next(head_q[fidx]);
	assign enq_go   = go && is_enq && idx_ok && !full;
	assign deq_go   = go && !is_enq && found;

	assign mem_we    = enq_go;
	assign mem_wdata = TAG_WIDTH'(cmd.item_tag);
	assign mem_waddr = AW'(qsel) * AW'(DEPTH) + AW'(tail_q[qsel]);
	assign mem_raddr = AW'(fidx) * AW'(DEPTH) + AW'(head_q[fidx]);

	always_comb begin
		info = '0;
		if (is_enq) begin
			priority if (!idx_ok) begin
				info.status = ST_INVALID;
			end else if (full) begin
				info.status = ST_FULL;
			end else begin
				info.status = ST_OK;
			end
		end else if (found) begin
			info.deq_ok       = 1'b1;
			info.status       = ST_OK;
			info.served_queue = QIDX_W'(fidx);
		end else begin
			info.status = ST_EMPTY;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qiu_q <= '0;
			for (int i = 0; i < N_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else if (cfg_we) begin
			qiu_q <= (32'(cfg_wdata) > N_QUEUES) ? CNT_W'(N_QUEUES) : CNT_W'(cfg_wdata);
			for (int i = 0; i < N_QUEUES; i++) begin
				head_q[i] <= '0;
				tail_q[i] <= '0;
			end
		end else begin
			if (enq_go) begin
				tail_q[qsel] <= tail_nxt;
			end
			if (deq_go) begin
				head_q[fidx] <= head_nxt;
			end
		end
	end

	`SPMQ_CHECK_NEXT(a_cfg_empties, cfg_we, nonempty == '0, "queue not empty after count write")
	`SPMQ_CHECK_NOW(a_count_limit, 1'b1, 32'(qiu_q) <= N_QUEUES, "queue count above limit")
	`SPMQ_CHECK_NOW(a_deq_in_use, deq_go, 32'(fidx) < 32'(qiu_q), "dequeue from unused queue")

endmodule
`default_nettype wire

// ===== sv/strict_priority_multi_queue.sv =====
// latency: the result word is strobed on done in the cycle after start is taken
// throughput: one command word per cycle, busy stays low; each word needs one
// tag ram access (one write port, one read port) and one pointer update in flops
// reset clears all head and tail pointers and the queue count; tag ram is not cleared
// the receiver cannot stall, each result is shown for exactly one cycle
`default_nettype none
module strict_priority_multi_queue import spmq_pkg::*; #(
	parameter int N_QUEUES   = N_QUEUES_DEF,
	parameter int DEPTH      = DEPTH_DEF,
	parameter int TAG_WIDTH  = TAG_WIDTH_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata,
	input  wire logic             start,
	output logic                  busy,
	input  wire cmd_word_t        cmd,
	output logic                  done,
	output result_word_t          result
);

	localparam int AW = $clog2(N_QUEUES * DEPTH);

	logic                 go;
	logic                 mem_we;
	logic [AW-1:0]        mem_waddr;
	logic [TAG_WIDTH-1:0] mem_wdata;
	logic [AW-1:0]        mem_raddr;
	logic [TAG_WIDTH-1:0] mem_rdata;
	step_info_t           info;
	step_info_t           info_s1;
	logic                 done_q;

	assign busy = 1'b0;
	assign go   = start && !busy;

	spmq_ptrs #(
		.N_QUEUES   (N_QUEUES),
		.DEPTH      (DEPTH),
		.TAG_WIDTH  (TAG_WIDTH)
	) u_ptrs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.go        (go),
		.cmd       (cmd),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.info      (info)
	);

	spmq_ram #(
		.WIDTH (TAG_WIDTH),
		.DEPTH (N_QUEUES * DEPTH)
	) u_tag_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= go;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			info_s1 <= info;
		end
	end

	assign done                = done_q;
	assign result.status       = info_s1.status;
	assign result.out_tag      = info_s1.deq_ok ? TAG_W'(mem_rdata) : '0;
	assign result.served_queue = info_s1.served_queue;

endmodule
`default_nettype wire
